>>> design/ude_pkg.sv
// Shared types and constants for the URL domain suffix extractor.
package ude_pkg;

  localparam int CHAR_W = 8;
  localparam int OUT_W  = 12;
  localparam int LVL_W  = 4;

  // front-to-back queue depth
  localparam int QDEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

  // byte class, produced by the front, consumed by the back
  typedef struct packed {
    logic is_zero;
    logic is_slash;
    logic is_colon;
    logic is_dot;
    logic is_w;
    logic is_digcol;
  } cls_t;

endpackage

>>> design/ude_front.sv
// Front end: accepts URL bytes, classifies them and queues the classes.
module ude_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ude_pkg::CHAR_W-1:0]  in_tdata,   // [7:0] char_code
  output logic                        q_valid,
  output ude_pkg::cls_t               q_item,
  input  logic                        q_pop
);

  localparam int PTR_W = (ude_pkg::QDEPTH > 1) ? $clog2(ude_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(ude_pkg::QDEPTH + 1);

  ude_pkg::cls_t            mem_r [ude_pkg::QDEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]         cnt_r;
  ude_pkg::cls_t            cls;
  logic                     push;

  always_comb begin
    cls.is_zero   = (in_tdata == ude_pkg::CH_NUL);
    cls.is_slash  = (in_tdata == ude_pkg::CH_SLASH);
    cls.is_colon  = (in_tdata == ude_pkg::CH_COLON);
    cls.is_dot    = (in_tdata == ude_pkg::CH_DOT);
    cls.is_w      = (in_tdata == ude_pkg::CH_W);
    cls.is_digcol = (in_tdata inside {[ude_pkg::CH_0:ude_pkg::CH_9], ude_pkg::CH_COLON});
  end

  assign in_tready = (cnt_r != CNT_W'(ude_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(ude_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (q_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  cnt_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ude_pkg::QDEPTH))
    else $error("queue count above depth");

  pop_nonempty_a: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> design/ude_back.sv
// Back end: host/domain tracking per byte and the result register.
module ude_back #(
  parameter int URL_MAX   = 4096,
  parameter int LEVEL_MAX = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [ude_pkg::LVL_W-1:0]   cfg_data,
  input  logic                        q_valid,
  input  ude_pkg::cls_t               q_item,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ude_pkg::OUT_W-1:0]   out_start,
  output logic [ude_pkg::OUT_W-1:0]   out_length,
  output logic                        out_too_long
);

  localparam int PW  = $clog2(URL_MAX);
  localparam int DCW = $clog2(LEVEL_MAX + 1);
  localparam int DIW = (LEVEL_MAX > 1) ? $clog2(LEVEL_MAX) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(URL_MAX - 1);

  localparam logic [1:0] PH_BEFORE  = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_IN_HOST = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [2:0] WWW_LAST = 3'd3;
  localparam logic [2:0] WWW_FULL = 3'd4;
  localparam logic [2:0] WWW_DONE = 3'd5;

  logic [ude_pkg::LVL_W-1:0] lvl_r;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic                      colon_r, colon_nxt;
  logic [PW-1:0]             host_r, host_nxt;
  logic [2:0]                www_r, www_nxt;
  logic [PW-1:0]             trim_r, trim_nxt;
  logic [DCW-1:0]            dcnt_r, dcnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [PW-1:0]             dot_r [LEVEL_MAX];
  logic                      dot_shift;
  logic                      out_valid_r, out_valid_nxt;
  logic [ude_pkg::OUT_W-1:0] start_r, len_r;
  logic                      tl_r;

  logic                      term;
  logic                      do_host, hb_skip, www_hit;
  logic [PW-1:0]             pos_inc;
  logic [4:0]                lvl_c;
  logic [PW-1:0]             end_c, beg_c, beg_sel;

  assign term  = q_pop && q_item.is_zero;
  assign q_pop = q_valid && (!q_item.is_zero || !out_valid_r || out_tready);
  assign pos_inc = pos_r + PW'(1);

  // result terms, used only on the terminating byte
  always_comb begin
    lvl_c = ({1'b0, lvl_r} > 5'(LEVEL_MAX)) ? 5'(LEVEL_MAX) : {1'b0, lvl_r};
    end_c = (trim_r < host_r) ? host_r : trim_r;
    beg_c = host_r;
    if (lvl_c != '0 && 5'(dcnt_r) >= lvl_c) begin
      beg_c = dot_r[DIW'(lvl_c - 5'd1)] + PW'(1);
    end
    beg_sel = (beg_c > end_c) ? end_c : beg_c;
  end

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    colon_nxt = colon_r;
    host_nxt  = host_r;
    www_nxt   = www_r;
    trim_nxt  = trim_r;
    dcnt_nxt  = dcnt_r;
    ovf_nxt   = ovf_r;
    dot_shift = 1'b0;
    do_host   = 1'b0;
    hb_skip   = 1'b0;
    www_hit   = 1'b0;
    if (q_pop) begin
      if (q_item.is_zero) begin
        pos_nxt   = '0;
        phase_nxt = PH_BEFORE;
        colon_nxt = 1'b0;
        host_nxt  = '0;
        www_nxt   = '0;
        trim_nxt  = '0;
        dcnt_nxt  = '0;
        ovf_nxt   = 1'b0;
      end else if (pos_r >= POS_LAST) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc;
        case (phase_r)
          PH_BEFORE: begin
            if (q_item.is_slash) begin
              phase_nxt = (pos_r != '0 && colon_r) ? PH_PENDING : PH_DONE;
            end else begin
              do_host = 1'b1;
            end
            colon_nxt = q_item.is_colon;
          end
          PH_PENDING: begin
            if (q_item.is_slash) begin
              host_nxt  = pos_inc;
              trim_nxt  = pos_inc;
              dcnt_nxt  = '0;
              www_nxt   = '0;
              phase_nxt = PH_IN_HOST;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_IN_HOST: begin
            if (q_item.is_slash) begin
              phase_nxt = PH_DONE;
            end else begin
              do_host = 1'b1;
            end
          end
          default: ;
        endcase

        if (do_host) begin
          if (www_r < WWW_FULL) begin
            www_hit = (www_r == WWW_LAST) ? q_item.is_dot : q_item.is_w;
            if (!www_hit) begin
              www_nxt = WWW_DONE;
            end else if (www_r == WWW_LAST) begin
              // "www." complete: host restarts after it
              host_nxt = pos_inc;
              trim_nxt = pos_inc;
              dcnt_nxt = '0;
              www_nxt  = WWW_DONE;
              hb_skip  = 1'b1;
            end else begin
              www_nxt = www_r + 3'd1;
            end
          end
          if (!hb_skip) begin
            if (!q_item.is_digcol) begin
              trim_nxt = pos_inc;
            end
            if (q_item.is_dot && pos_r > host_r) begin
              dot_shift = 1'b1;
              if (dcnt_r < DCW'(LEVEL_MAX)) begin
                dcnt_nxt = dcnt_r + DCW'(1);
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (term) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= '0;
      pos_r       <= '0;
      phase_r     <= PH_BEFORE;
      colon_r     <= 1'b0;
      host_r      <= '0;
      www_r       <= '0;
      trim_r      <= '0;
      dcnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lvl_r <= cfg_data;
      end
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      colon_r     <= colon_nxt;
      host_r      <= host_nxt;
      www_r       <= www_nxt;
      trim_r      <= trim_nxt;
      dcnt_r      <= dcnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // newest dot in entry 0
  always_ff @(posedge clk) begin
    if (dot_shift) begin
      dot_r[0] <= pos_r;
      for (int i = 1; i < LEVEL_MAX; i++) begin
        dot_r[i] <= dot_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term) begin
      start_r <= ude_pkg::OUT_W'(beg_sel);
      len_r   <= ude_pkg::OUT_W'(end_c - beg_sel);
      tl_r    <= ovf_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_start    = start_r;
  assign out_length   = len_r;
  assign out_too_long = tl_r;

  dcnt_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DCW'(LEVEL_MAX))
    else $error("dot count above limit");

  pos_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position past buffer end");

  term_clears_a: assert property (@(posedge clk) disable iff (!rst_n)
    term |=> (pos_r == '0 && dcnt_r == '0 && !ovf_r && out_valid_r))
    else $error("terminator did not clear state and load result");

  plain_byte_no_result_a: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_item.is_zero && !out_valid_r) |=> !out_valid_r)
    else $error("result raised by a non-terminating byte");

endmodule

>>> design/url_domain_suffix_extract_unit.sv
// URL domain suffix extractor, top level.
//
// Usage: URL bytes enter on in_* one beat per byte; a zero byte ends the URL.
// For each zero byte one result beat leaves on out_*: the domain's byte
// offset and length within the URL, plus a too-long flag in out_tuser when
// bytes past the buffer were dropped. Nonzero bytes produce no output.
// cfg_* writes domain_level (labels kept; 0 = whole host, above LEVEL_MAX acts
// as LEVEL_MAX); write it only while no URL is in flight. cfg_ready is always 1.
// Throughput: one byte per cycle while results are taken. A byte is classified
// and placed in a 4-entry queue; the back end applies one queued byte per
// cycle to the host tracking state, loading the result on the zero byte's pop.
// If the receiver stalls, the result is held; nonzero bytes keep draining, a
// second zero byte waits in the queue, and in_tready drops once it is full.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result,
// clears the URL state and sets domain_level to 0.
module url_domain_suffix_extract_unit #(
  parameter int URL_MAX   = 4096,
  parameter int LEVEL_MAX = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [11:0] domain_start, [23:12] domain_length
  output logic [0:0]  out_tuser,   // [0] too_long
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data     // [3:0] domain_level
);

  logic                      q_valid;
  logic                      q_pop;
  ude_pkg::cls_t             q_item;
  logic [ude_pkg::OUT_W-1:0] dom_start, dom_len;
  logic                      too_long;

  assign cfg_ready = 1'b1;

  ude_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ude_back #(
    .URL_MAX   (URL_MAX),
    .LEVEL_MAX (LEVEL_MAX)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_start    (dom_start),
    .out_length   (dom_len),
    .out_too_long (too_long)
  );

  assign out_tdata = {dom_len, dom_start};
  assign out_tuser = too_long;

endmodule
